>>> design/ipr_pkg.sv
package ipr_pkg;

  localparam int MAX_ACTIVITIES_DEF = 32;
  localparam int TIME_BITS_DEF      = 16;

  typedef struct packed {
    logic [15:0] start_time;
    logic [15:0] end_time;
    logic        last_item;
  } request_t;

  typedef struct packed {
    logic [5:0] activity_number;
    logic [5:0] room;
    logic [5:0] room_count;
    logic       last_result;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PLACE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic ins;
    logic rot;
    logic clr;
  } cell_ctl_t;

  typedef struct packed {
    logic search;
    logic init;
    logic inc;
    logic clr;
  } room_ctl_t;

endpackage

>>> design/ipr_cell.sv
module ipr_cell #(
  parameter int TIME_BITS = ipr_pkg::TIME_BITS_DEF,
  parameter int NUM_W     = 5,
  parameter int ROOM_W    = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ipr_pkg::cell_ctl_t    ctl,
  input  logic [TIME_BITS-1:0]  new_st,
  input  logic [TIME_BITS-1:0]  new_en,
  input  logic [NUM_W-1:0]      new_num,
  input  logic                  prev_keep,
  output logic                  keep,
  input  logic                  prev_valid,
  input  logic [TIME_BITS-1:0]  prev_st,
  input  logic [TIME_BITS-1:0]  prev_en,
  input  logic [NUM_W-1:0]      prev_num,
  input  logic                  next_valid,
  input  logic [TIME_BITS-1:0]  next_st,
  input  logic [TIME_BITS-1:0]  next_en,
  input  logic [NUM_W-1:0]      next_num,
  input  logic [ROOM_W-1:0]     next_room,
  input  logic [TIME_BITS-1:0]  wrap_st,
  input  logic [TIME_BITS-1:0]  wrap_en,
  input  logic [NUM_W-1:0]      wrap_num,
  input  logic [ROOM_W-1:0]     wrap_room,
  output logic                  valid,
  output logic [TIME_BITS-1:0]  st,
  output logic [TIME_BITS-1:0]  en,
  output logic [NUM_W-1:0]      num,
  output logic [ROOM_W-1:0]     room
);

  // stay put when holding an end time no later than the incoming one
  assign keep = valid && (en <= new_en);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      room  <= '0;
    end else if (ctl.clr) begin
      valid <= 1'b0;
      room  <= '0;
    end else if (ctl.ins && !keep) begin
      room <= '0;
      if (prev_keep) begin
        valid <= 1'b1;
        st    <= new_st;
        en    <= new_en;
        num   <= new_num;
      end else begin
        valid <= prev_valid;
        st    <= prev_st;
        en    <= prev_en;
        num   <= prev_num;
      end
    end else if (ctl.rot && valid) begin
      if (next_valid) begin
        st   <= next_st;
        en   <= next_en;
        num  <= next_num;
        room <= next_room;
      end else begin
        st   <= wrap_st;
        en   <= wrap_en;
        num  <= wrap_num;
        room <= wrap_room;
      end
    end
  end

endmodule

>>> design/ipr_rooms.sv
module ipr_rooms #(
  parameter int MAX_ACTIVITIES = ipr_pkg::MAX_ACTIVITIES_DEF,
  parameter int TIME_BITS      = ipr_pkg::TIME_BITS_DEF,
  parameter int ROOM_W         = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ipr_pkg::room_ctl_t   ctl,
  input  logic [TIME_BITS-1:0] act_st,
  input  logic [TIME_BITS-1:0] act_en,
  output logic                 hit,
  output logic [ROOM_W-1:0]    hit_room,
  output logic [ROOM_W-1:0]    open_rooms
);

  logic [TIME_BITS-1:0]      room_end [MAX_ACTIVITIES];
  logic [MAX_ACTIVITIES-1:0] fit;
  logic [MAX_ACTIVITIES-1:0] sel;

  always_comb begin
    hit      = 1'b0;
    hit_room = '0;
    sel      = '0;
    for (int j = 0; j < MAX_ACTIVITIES; j++) begin
      fit[j] = (ROOM_W'(j) < open_rooms) && (act_st >= room_end[j]);
    end
    for (int j = MAX_ACTIVITIES - 1; j >= 0; j--) begin
      if (fit[j]) begin
        hit      = 1'b1;
        hit_room = ROOM_W'(j + 1);
        sel      = '0;
        sel[j]   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      open_rooms <= '0;
      for (int j = 0; j < MAX_ACTIVITIES; j++) begin
        room_end[j] <= '0;
      end
    end else begin
      if (ctl.init) begin
        open_rooms <= ROOM_W'(1);
      end else if (ctl.inc && (open_rooms < ROOM_W'(MAX_ACTIVITIES))) begin
        open_rooms <= open_rooms + ROOM_W'(1);
      end
      for (int j = 0; j < MAX_ACTIVITIES; j++) begin
        if (ctl.search && sel[j]) begin
          room_end[j] <= act_en;
        end
      end
    end
  end

endmodule

>>> design/interval_room_partitioner.sv
// Load: one activity per cycle while busy is low; a transaction with last_item set starts a run.
// Run: passes over the cell row, each visiting every sorted activity in turn (passes <= n),
//   then n results, one per cycle; results appear in the cycle after their emit step.
// Reset (synchronous, rst high) empties the row, closes all rooms and returns to idle.
// The receiver cannot stall: each result is shown for exactly one cycle with result_valid.
module interval_room_partitioner #(
  parameter int MAX_ACTIVITIES = ipr_pkg::MAX_ACTIVITIES_DEF,
  parameter int TIME_BITS      = ipr_pkg::TIME_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ipr_pkg::request_t request,
  output logic              result_valid,
  output ipr_pkg::result_t  result
);

  localparam int CNT_W  = $clog2(MAX_ACTIVITIES + 1);
  localparam int IDX_W  = (MAX_ACTIVITIES > 1) ? $clog2(MAX_ACTIVITIES) : 1;
  localparam int ROOM_W = CNT_W;

  ipr_pkg::state_t    state, state_next;
  ipr_pkg::cell_ctl_t cell_ctl;
  ipr_pkg::room_ctl_t room_ctl;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] placed;
  logic [IDX_W-1:0] pos;

  // Cell row, kept sorted by end time (ties in arrival order). Cell 0 is the head.
  logic                 c_valid [MAX_ACTIVITIES];
  logic [TIME_BITS-1:0] c_st    [MAX_ACTIVITIES];
  logic [TIME_BITS-1:0] c_en    [MAX_ACTIVITIES];
  logic [IDX_W-1:0]     c_num   [MAX_ACTIVITIES];
  logic [ROOM_W-1:0]    c_room  [MAX_ACTIVITIES];
  logic                 c_keep  [MAX_ACTIVITIES];

  logic [TIME_BITS-1:0] new_st, new_en;
  logic                 accept;
  logic                 head_open;
  logic                 hit;
  logic [ROOM_W-1:0]    hit_room;
  logic [ROOM_W-1:0]    open_rooms;
  logic [ROOM_W-1:0]    wrap_room;
  logic                 pos_last;
  logic                 place_now;
  logic [CNT_W-1:0]     placed_now;

  // Mask the incoming times to the stored width.
  assign new_st = TIME_BITS'(32'(request.start_time));
  assign new_en = TIME_BITS'(32'(request.end_time));

  assign busy      = (state != ipr_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign head_open = (c_room[0] == '0);
  assign pos_last  = (CNT_W'(pos) == (count - CNT_W'(1)));

  // A head that is still unplaced takes the lowest open room that is free by its start.
  assign place_now  = (state == ipr_pkg::ST_PLACE) && head_open && hit;
  assign placed_now = placed + CNT_W'(place_now);
  assign wrap_room  = place_now ? hit_room : c_room[0];

  for (genvar i = 0; i < MAX_ACTIVITIES; i++) begin : g_cell
    logic                 pk, pv, nv;
    logic [TIME_BITS-1:0] ps, pe, ns, ne;
    logic [IDX_W-1:0]     pn, nn;
    logic [ROOM_W-1:0]    nr;
    if (i == 0) begin : g_first
      assign pk = 1'b1;
      assign pv = 1'b0;
      assign ps = '0;
      assign pe = '0;
      assign pn = '0;
    end else begin : g_mid
      assign pk = c_keep[i-1];
      assign pv = c_valid[i-1];
      assign ps = c_st[i-1];
      assign pe = c_en[i-1];
      assign pn = c_num[i-1];
    end
    if (i == MAX_ACTIVITIES - 1) begin : g_last
      assign nv = 1'b0;
      assign ns = '0;
      assign ne = '0;
      assign nn = '0;
      assign nr = '0;
    end else begin : g_inner
      assign nv = c_valid[i+1];
      assign ns = c_st[i+1];
      assign ne = c_en[i+1];
      assign nn = c_num[i+1];
      assign nr = c_room[i+1];
    end

    ipr_cell #(
      .TIME_BITS(TIME_BITS),
      .NUM_W    (IDX_W),
      .ROOM_W   (ROOM_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (cell_ctl),
      .new_st    (new_st),
      .new_en    (new_en),
      .new_num   (count[IDX_W-1:0]),
      .prev_keep (pk),
      .keep      (c_keep[i]),
      .prev_valid(pv),
      .prev_st   (ps),
      .prev_en   (pe),
      .prev_num  (pn),
      .next_valid(nv),
      .next_st   (ns),
      .next_en   (ne),
      .next_num  (nn),
      .next_room (nr),
      .wrap_st   (c_st[0]),
      .wrap_en   (c_en[0]),
      .wrap_num  (c_num[0]),
      .wrap_room (wrap_room),
      .valid     (c_valid[i]),
      .st        (c_st[i]),
      .en        (c_en[i]),
      .num       (c_num[i]),
      .room      (c_room[i])
    );
  end

  ipr_rooms #(
    .MAX_ACTIVITIES(MAX_ACTIVITIES),
    .TIME_BITS     (TIME_BITS),
    .ROOM_W        (ROOM_W)
  ) u_rooms (
    .clk       (clk),
    .rst       (rst),
    .ctl       (room_ctl),
    .act_st    (c_st[0]),
    .act_en    (c_en[0]),
    .hit       (hit),
    .hit_room  (hit_room),
    .open_rooms(open_rooms)
  );

  // Next state: load until last, make passes until every activity has a room, then emit.
  always_comb begin
    state_next = state;
    case (state)
      ipr_pkg::ST_IDLE: begin
        if (accept && request.last_item) state_next = ipr_pkg::ST_PLACE;
      end
      ipr_pkg::ST_PLACE: begin
        if (pos_last && (placed_now == count)) state_next = ipr_pkg::ST_EMIT;
      end
      ipr_pkg::ST_EMIT: begin
        if (pos_last) state_next = ipr_pkg::ST_IDLE;
      end
      default: state_next = ipr_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: row and room-table controls.
  always_comb begin
    cell_ctl = '0;
    room_ctl = '0;
    case (state)
      ipr_pkg::ST_IDLE: begin
        // insert in sorted place; drop once the row is full
        cell_ctl.ins  = accept && (count < CNT_W'(MAX_ACTIVITIES));
        room_ctl.init = accept && request.last_item;
      end
      ipr_pkg::ST_PLACE: begin
        cell_ctl.rot    = 1'b1;
        room_ctl.search = head_open;
        // open one more room after a pass that leaves someone unplaced
        room_ctl.inc    = pos_last && (placed_now != count);
      end
      ipr_pkg::ST_EMIT: begin
        cell_ctl.rot = 1'b1;
        cell_ctl.clr = pos_last;
        room_ctl.clr = pos_last;
      end
      default: begin
        cell_ctl = '0;
        room_ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ipr_pkg::ST_IDLE;
      count        <= '0;
      placed       <= '0;
      pos          <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= (state == ipr_pkg::ST_EMIT);
      case (state)
        ipr_pkg::ST_IDLE: begin
          pos    <= '0;
          placed <= '0;
          if (cell_ctl.ins) count <= count + CNT_W'(1);
        end
        ipr_pkg::ST_PLACE: begin
          placed <= placed_now;
          pos    <= pos_last ? '0 : pos + IDX_W'(1);
        end
        ipr_pkg::ST_EMIT: begin
          pos <= pos_last ? '0 : pos + IDX_W'(1);
          if (pos_last) count <= '0;
        end
        default: begin
          pos <= '0;
        end
      endcase
    end
  end

  // Register the head activity as the result of this emit step.
  always_ff @(posedge clk) begin
    if (state == ipr_pkg::ST_EMIT) begin
      result.activity_number <= 6'(32'(c_num[0]) + 32'd1);
      result.room            <= 6'(c_room[0]);
      result.room_count      <= 6'(open_rooms);
      result.last_result     <= pos_last;
    end
  end

endmodule
